// ----- hw/rtl/ssch_pkg.sv -----
// ---------------------------------------------------------------------------
// Stride scheduler package
// Shared constants and command/status codes for the stride scheduler.
// ---------------------------------------------------------------------------
package ssch_pkg;

  localparam int unsigned MAX_JOBS_DEF   = 16;
  localparam int unsigned PASS_WIDTH_DEF = 32;

  // stride = STRIDE_BASE / priority
  localparam int unsigned STRIDE_BASE = 100000;
  localparam int unsigned STRIDE_W    = 17;
  localparam int unsigned PRIO_W      = 16;
  localparam int unsigned NAME_W      = 8;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned OPASS_W     = 32;
  localparam int unsigned COUNT_W     = 5;

  localparam logic [MODE_W-1:0] MODE_NEW       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FINISH    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INTERRUPT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BLOCK     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_UNBLOCK   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_QUEUED      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SCHEDULED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_IDLE        = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNBLOCKED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ERR_IDLE    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ERR_NOT_BLK = 3'd5;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL  = 3'd6;

endpackage

// ----- hw/rtl/stride_scheduler.sv -----
// ---------------------------------------------------------------------------
// Stride scheduler
// Job table with one running job; each command beat gives one result beat.
// ---------------------------------------------------------------------------
// One command is taken at a time. Each command sweeps the whole job table
// through the single read port of the entry RAM, one entry a cycle, to find
// the least runnable (pass, name), the lowest free entry and the first
// blocked entry of the given name; the command step then applies it.
// A new-job command also waits in the command step for the stride divider,
// started at acceptance. The result beat sits in an output register, so the
// next command may be taken while it waits; a result still waiting there
// holds the command step of the next command until it is taken. No clearing
// pass is needed after reset: per-entry valid and blocked flags live in
// flip-flops.
module stride_scheduler #(
  parameter int unsigned MAX_JOBS   = ssch_pkg::MAX_JOBS_DEF,
  parameter int unsigned PASS_WIDTH = ssch_pkg::PASS_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // mode[2:0], job_name[10:3], priority_req[26:11]
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], result_name[10:3], result_pass[42:11], running_valid[43],
  // runnable_count[48:44], blocked_count[53:49]
  output logic [55:0] out_tdata
);

  localparam int unsigned IW  = $clog2(MAX_JOBS);
  localparam int unsigned CW  = $clog2(MAX_JOBS + 1);
  localparam int unsigned PW  = PASS_WIDTH;
  localparam int unsigned NW  = ssch_pkg::NAME_W;
  localparam int unsigned SW  = ssch_pkg::STRIDE_W;
  localparam int unsigned EW  = NW + SW + PW;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC} state_t;

  state_t state_r;

  // command
  logic [ssch_pkg::MODE_W-1:0] mode_r;
  logic [NW-1:0]               name_r;

  // running job
  logic          run_valid_r;
  logic [NW-1:0] run_name_r;
  logic [SW-1:0] run_stride_r;
  logic [PW-1:0] run_pass_r;

  // per-entry flags and counts
  logic [MAX_JOBS-1:0] valid_r;
  logic [MAX_JOBS-1:0] blk_r;
  logic [CW-1:0]       nrun_r;
  logic [CW-1:0]       nblk_r;

  // sweep
  logic [IW:0]   cnt_r;
  logic          pend_r;
  logic [IW-1:0] pidx_r;
  logic          m_found_r;
  logic [IW-1:0] m_idx_r;
  logic [NW-1:0] m_name_r;
  logic [SW-1:0] m_stride_r;
  logic [PW-1:0] m_pass_r;
  logic          f_found_r;
  logic [IW-1:0] f_idx_r;
  logic          u_found_r;
  logic [IW-1:0] u_idx_r;
  logic [SW-1:0] u_stride_r;

  // output beat
  logic        out_valid_r;
  logic [55:0] out_data_r;

  // entry RAM
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;
  logic [NW-1:0] rd_name;
  logic [SW-1:0] rd_stride;
  logic [PW-1:0] rd_pass;

  // divider
  logic          div_start;
  logic          div_busy;
  logic [SW-1:0] div_quo;

  logic          in_fire;
  logic          exec_go;
  logic [PW:0]   sat_sum;
  logic [PW-1:0] run_pass_int;
  logic          rd_runnable;
  logic          rd_better;

  // applied by the command step
  logic          run_valid_nxt;
  logic [NW-1:0] run_name_nxt;
  logic [SW-1:0] run_stride_nxt;
  logic [PW-1:0] run_pass_nxt;
  logic          vb_we;
  logic [IW-1:0] vb_idx;
  logic          vb_valid;
  logic          vb_blk;
  logic [CW-1:0] nrun_nxt;
  logic [CW-1:0] nblk_nxt;
  logic [ssch_pkg::STATUS_W-1:0] st;
  logic [NW-1:0] rname;
  logic [PW-1:0] rpass;
  logic          run_loses;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign div_start = in_fire && (in_tdata[2:0] == ssch_pkg::MODE_NEW);
  assign exec_go   = (state_r == S_EXEC) && !div_busy && (!out_valid_r || out_tready);

  // saturating pass advance for an interrupt, taken at acceptance
  assign sat_sum      = {1'b0, run_pass_r} + (PW + 1)'(run_stride_r);
  assign run_pass_int = sat_sum[PW] ? '1 : sat_sum[PW-1:0];

  assign {rd_name, rd_stride, rd_pass} = ram_rdata;
  assign rd_runnable = valid_r[pidx_r] && !blk_r[pidx_r];
  assign rd_better   = (rd_pass < m_pass_r) || ((rd_pass == m_pass_r) && (rd_name < m_name_r));
  assign run_loses   = (m_pass_r < run_pass_r) ||
                       ((m_pass_r == run_pass_r) && (m_name_r < run_name_r));

  ssch_ram #(.WIDTH(EW), .DEPTH(MAX_JOBS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  ssch_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (in_tdata[26:11]),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // command step: decide table writes, running job and result
  always_comb begin
    ram_we         = 1'b0;
    ram_waddr      = m_idx_r;
    ram_wdata      = {run_name_r, run_stride_r, run_pass_r};
    run_valid_nxt  = run_valid_r;
    run_name_nxt   = run_name_r;
    run_stride_nxt = run_stride_r;
    run_pass_nxt   = run_pass_r;
    vb_we          = 1'b0;
    vb_idx         = m_idx_r;
    vb_valid       = 1'b1;
    vb_blk         = 1'b0;
    nrun_nxt       = nrun_r;
    nblk_nxt       = nblk_r;
    st             = ssch_pkg::ST_ERR_IDLE;
    rname          = '0;
    rpass          = '0;
    unique case (mode_r)
      ssch_pkg::MODE_NEW: begin
        if (!run_valid_r) begin
          run_valid_nxt  = 1'b1;
          run_name_nxt   = name_r;
          run_stride_nxt = div_quo;
          run_pass_nxt   = '0;
          st             = ssch_pkg::ST_SCHEDULED;
          rname          = name_r;
        end else if (!f_found_r) begin
          st = ssch_pkg::ST_TABLE_FULL;
        end else begin
          rpass     = m_found_r ? m_pass_r : run_pass_r;
          ram_we    = 1'b1;
          ram_waddr = f_idx_r;
          ram_wdata = {name_r, div_quo, rpass};
          vb_we     = 1'b1;
          vb_idx    = f_idx_r;
          nrun_nxt  = nrun_r + CW'(1);
          st        = ssch_pkg::ST_QUEUED;
          rname     = name_r;
        end
      end
      ssch_pkg::MODE_FINISH: begin
        if (run_valid_r) begin
          if (!m_found_r) begin
            run_valid_nxt  = 1'b0;
            run_name_nxt   = '0;
            run_stride_nxt = '0;
            run_pass_nxt   = '0;
            st             = ssch_pkg::ST_IDLE;
          end else begin
            run_name_nxt   = m_name_r;
            run_stride_nxt = m_stride_r;
            run_pass_nxt   = m_pass_r;
            vb_we          = 1'b1;
            vb_valid       = 1'b0;
            nrun_nxt       = nrun_r - CW'(1);
            st             = ssch_pkg::ST_SCHEDULED;
            rname          = m_name_r;
            rpass          = m_pass_r;
          end
        end
      end
      ssch_pkg::MODE_INTERRUPT: begin
        if (run_valid_r) begin
          st    = ssch_pkg::ST_SCHEDULED;
          rname = run_name_r;
          rpass = run_pass_r;
          if (m_found_r && run_loses) begin
            ram_we         = 1'b1;
            run_name_nxt   = m_name_r;
            run_stride_nxt = m_stride_r;
            run_pass_nxt   = m_pass_r;
            rname          = m_name_r;
            rpass          = m_pass_r;
          end
        end
      end
      ssch_pkg::MODE_BLOCK: begin
        if (run_valid_r) begin
          if (m_found_r) begin
            ram_we         = 1'b1;
            vb_we          = 1'b1;
            vb_blk         = 1'b1;
            run_name_nxt   = m_name_r;
            run_stride_nxt = m_stride_r;
            run_pass_nxt   = m_pass_r;
            nrun_nxt       = nrun_r - CW'(1);
            nblk_nxt       = nblk_r + CW'(1);
            st             = ssch_pkg::ST_SCHEDULED;
            rname          = m_name_r;
            rpass          = m_pass_r;
          end else if (!f_found_r) begin
            st = ssch_pkg::ST_TABLE_FULL;
          end else begin
            ram_we         = 1'b1;
            ram_waddr      = f_idx_r;
            vb_we          = 1'b1;
            vb_idx         = f_idx_r;
            vb_blk         = 1'b1;
            nblk_nxt       = nblk_r + CW'(1);
            run_valid_nxt  = 1'b0;
            run_name_nxt   = '0;
            run_stride_nxt = '0;
            run_pass_nxt   = '0;
            st             = ssch_pkg::ST_IDLE;
          end
        end
      end
      ssch_pkg::MODE_UNBLOCK: begin
        if (!u_found_r) begin
          st = ssch_pkg::ST_ERR_NOT_BLK;
        end else begin
          rpass     = run_valid_r ? run_pass_r : (m_found_r ? m_pass_r : '0);
          ram_we    = 1'b1;
          ram_waddr = u_idx_r;
          ram_wdata = {name_r, u_stride_r, rpass};
          vb_we     = 1'b1;
          vb_idx    = u_idx_r;
          nrun_nxt  = nrun_r + CW'(1);
          nblk_nxt  = nblk_r - CW'(1);
          st        = ssch_pkg::ST_UNBLOCKED;
          rname     = name_r;
        end
      end
      default: begin
        st = ssch_pkg::ST_ERR_IDLE;
      end
    endcase
    if (!exec_go) begin
      ram_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      run_valid_r  <= 1'b0;
      run_name_r   <= '0;
      run_stride_r <= '0;
      run_pass_r   <= '0;
      valid_r      <= '0;
      blk_r        <= '0;
      nrun_r       <= '0;
      nblk_r       <= '0;
      pend_r       <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // load a new result beat, else drop the one just taken
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            mode_r    <= in_tdata[2:0];
            name_r    <= in_tdata[10:3];
            cnt_r     <= '0;
            pend_r    <= 1'b0;
            m_found_r <= 1'b0;
            f_found_r <= 1'b0;
            u_found_r <= 1'b0;
            // advance the pass before the sweep so the step compares the new pass
            if ((in_tdata[2:0] == ssch_pkg::MODE_INTERRUPT) && run_valid_r) begin
              run_pass_r <= run_pass_int;
            end
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue one read a cycle, judge the entry read the cycle before
          pend_r <= (cnt_r < (IW + 1)'(MAX_JOBS));
          pidx_r <= cnt_r[IW-1:0];
          if (cnt_r < (IW + 1)'(MAX_JOBS)) begin
            cnt_r <= cnt_r + (IW + 1)'(1);
          end
          if (pend_r) begin
            if (rd_runnable && (!m_found_r || rd_better)) begin
              m_found_r  <= 1'b1;
              m_idx_r    <= pidx_r;
              m_name_r   <= rd_name;
              m_stride_r <= rd_stride;
              m_pass_r   <= rd_pass;
            end
            if (!valid_r[pidx_r] && !f_found_r) begin
              f_found_r <= 1'b1;
              f_idx_r   <= pidx_r;
            end
            if (valid_r[pidx_r] && blk_r[pidx_r] && !u_found_r && (rd_name == name_r)) begin
              u_found_r  <= 1'b1;
              u_idx_r    <= pidx_r;
              u_stride_r <= rd_stride;
            end
          end
          if ((cnt_r == (IW + 1)'(MAX_JOBS)) && !pend_r) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            run_valid_r  <= run_valid_nxt;
            run_name_r   <= run_name_nxt;
            run_stride_r <= run_stride_nxt;
            run_pass_r   <= run_pass_nxt;
            if (vb_we) begin
              valid_r[vb_idx] <= vb_valid;
              blk_r[vb_idx]   <= vb_blk;
            end
            nrun_r      <= nrun_nxt;
            nblk_r      <= nblk_nxt;
            out_data_r  <= {2'b00, ssch_pkg::COUNT_W'(nblk_nxt),
                            ssch_pkg::COUNT_W'(nrun_nxt), run_valid_nxt,
                            ssch_pkg::OPASS_W'(rpass), rname, st};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == (32'(nrun_r) + 32'(nblk_r)))
    else $error("entry counts disagree with valid flags");

  a_blk_subset: assert property (@(posedge clk) disable iff (!rst_n)
    (blk_r & ~valid_r) == '0)
    else $error("blocked flag on an empty entry");

  a_sched_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r[2:0] == ssch_pkg::ST_SCHEDULED)) |-> out_data_r[43])
    else $error("scheduled result with no running job");

endmodule

// ----- hw/rtl/ssch_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module ssch_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/ssch_div.sv -----
// ---------------------------------------------------------------------------
// Stride divider
// Restoring division of the stride base by a priority, one bit a cycle.
// ---------------------------------------------------------------------------
module ssch_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ssch_pkg::PRIO_W-1:0]  divisor,
  output logic                         busy,
  output logic [ssch_pkg::STRIDE_W-1:0] quotient
);

  localparam int unsigned SW = ssch_pkg::STRIDE_W;
  localparam int unsigned CW = $clog2(SW + 1);

  logic [SW-1:0] rem_r;
  logic [SW-1:0] quo_r;
  logic [ssch_pkg::PRIO_W-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [SW-1:0] rem_sh;
  logic          take;

  assign rem_sh = {rem_r[SW-2:0], quo_r[SW-1]};
  assign take   = rem_sh >= SW'(dvs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(SW);
      rem_r  <= '0;
      quo_r  <= SW'(ssch_pkg::STRIDE_BASE);
      dvs_r  <= (divisor == '0) ? ssch_pkg::PRIO_W'(1) : divisor;
    end else if (busy_r) begin
      rem_r  <= take ? (rem_sh - SW'(dvs_r)) : rem_sh;
      quo_r  <= {quo_r[SW-2:0], take};
      cnt_r  <= cnt_r - CW'(1);
      busy_r <= (cnt_r != CW'(1));
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

  // the base exceeds any 16-bit priority, so a finished stride is never zero
  a_quo_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> (quo_r != '0))
    else $error("stride of zero after division");

endmodule
